[hw/rtl/reversible_double_ended_queue_defines.svh]
// Assertion macros shared by the RTL files of the queue block.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef REVERSIBLE_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define REVERSIBLE_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define RDEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define RDEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	`RDEQ_ASSERT(lbl, (ante) |-> (cons), msg)

// A consequent that must hold in the cycle after its antecedent.
`define RDEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	`RDEQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/rdeq_pkg.sv]
package rdeq_pkg;

	// Ring size, the widths that follow from it, and the value and func widths.
	localparam int DEPTH = 256;
	localparam int PTR_W = 8;
	localparam int CNT_W = 9;
	localparam int VAL_W = 32;
	localparam int FUNC_W = 2;

	// Operation codes carried by an input item.
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 2'd0,
		FN_INS_BACK  = 2'd1,
		FN_REM_FRONT = 2'd2,
		FN_REVERSE   = 2'd3
	} func_t;

	// Step a ring pointer forward, wrapping at the end of the ring.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// Step a ring pointer back, wrapping at the start of the ring.
	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(DEPTH - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

endpackage

[hw/rtl/rdeq_ram.sv]
module rdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// One read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/reversible_double_ended_queue.sv]
// Bounded double-ended queue of 32-bit signed values with an order reversal.
// Input channel s_*: each item is one operation, selected by s_tuser
// (insert front, insert back, remove front, reverse) with the value to insert
// in s_tdata. Output channel m_*: one result item per operation, with the
// success flag in m_tuser and the removed value and the count after the
// operation in m_tdata.
// An accepted input item passes the stage register, then the output register, to m_*.
// Throughput is one item per cycle while the receiver takes results: the ring is
// read and written at acceptance, and the read data enters the output register.
// Reversal moves no data; it flips which physical end is the logical front.
// Reset leaves an empty queue in normal order; the ring contents are not
// cleared, so the block takes items right after reset.
// When the receiver stalls, the output register holds its result and one
// more item finishes into the stage behind it; then s_tready drops until the
// receiver takes the waiting result.
`include "reversible_double_ended_queue_defines.svh"

module reversible_double_ended_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] in_value
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] out_value, [40:32] count, [47:41] zero
	output logic        m_tuser    // [0] ok
);

	localparam int PW = rdeq_pkg::PTR_W;
	localparam int CW = rdeq_pkg::CNT_W;
	localparam int VW = rdeq_pkg::VAL_W;

	// Queue state.
	logic [PW-1:0] front_q;
	logic [PW-1:0] back_q;
	logic [CW-1:0] occ_q;
	logic          rev_q;

	// Stage behind acceptance, waiting for the ring read data.
	logic          s1_valid_q;
	logic          ok_s1;
	logic          rd_s1;
	logic [CW-1:0] cnt_s1;

	// Output register.
	logic          out_valid_q;
	logic          out_ok_q;
	logic [VW-1:0] out_value_q;
	logic [CW-1:0] out_count_q;

	// Next-state values for the operation at the input.
	rdeq_pkg::func_t func;
	logic          acc;
	logic          s1_adv;
	logic          full;
	logic          empty;
	logic          at_front;
	logic          ins_ok;
	logic          rem_ok;
	logic          op_ok;
	logic [PW-1:0] nxt_front;
	logic [PW-1:0] nxt_back;
	logic [CW-1:0] nxt_occ;
	logic          nxt_rev;
	logic [PW-1:0] waddr;
	logic [PW-1:0] raddr;
	logic [VW-1:0] rdata;
	logic          wr_en;
	logic          rd_en;

	assign func   = rdeq_pkg::func_t'(s_tuser);
	assign s1_adv = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign acc    = s_tvalid && s_tready;
	assign full   = (occ_q == CW'(rdeq_pkg::DEPTH));
	assign empty  = (occ_q == '0);

	// Decode the operation and work out pointers, count and ring access.
	always_comb begin
		nxt_front = front_q;
		nxt_back  = back_q;
		nxt_occ   = occ_q;
		nxt_rev   = rev_q;
		waddr     = back_q;
		raddr     = front_q;
		ins_ok    = 1'b0;
		rem_ok    = 1'b0;
		op_ok     = 1'b0;
		at_front  = ((func == rdeq_pkg::FN_INS_FRONT) == !rev_q);
		case (func)
			rdeq_pkg::FN_INS_FRONT,
			rdeq_pkg::FN_INS_BACK: begin
				if (!full) begin
					ins_ok = 1'b1;
					op_ok  = 1'b1;
					nxt_occ = occ_q + CW'(1);
					if (at_front) begin
						nxt_front = rdeq_pkg::ptr_dec(front_q);
						waddr     = rdeq_pkg::ptr_dec(front_q);
					end else begin
						waddr    = back_q;
						nxt_back = rdeq_pkg::ptr_inc(back_q);
					end
				end
			end
			rdeq_pkg::FN_REM_FRONT: begin
				if (!empty) begin
					rem_ok  = 1'b1;
					op_ok   = 1'b1;
					nxt_occ = occ_q - CW'(1);
					if (!rev_q) begin
						raddr     = front_q;
						nxt_front = rdeq_pkg::ptr_inc(front_q);
					end else begin
						raddr    = rdeq_pkg::ptr_dec(back_q);
						nxt_back = rdeq_pkg::ptr_dec(back_q);
					end
				end
			end
			rdeq_pkg::FN_REVERSE: begin
				op_ok   = 1'b1;
				nxt_rev = !rev_q;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign wr_en = acc && ins_ok;
	assign rd_en = acc && rem_ok;

	// Ring store.
	rdeq_ram #(
		.WIDTH(VW),
		.DEPTH(rdeq_pkg::DEPTH),
		.AW(PW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(s_tdata),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Queue state and stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			back_q      <= '0;
			occ_q       <= '0;
			rev_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				front_q <= nxt_front;
				back_q  <= nxt_back;
				occ_q   <= nxt_occ;
				rev_q   <= nxt_rev;
			end
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload through the stage and into the output register.
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1  <= op_ok;
			rd_s1  <= rem_ok;
			cnt_s1 <= nxt_occ;
		end
		if (s1_adv) begin
			out_ok_q    <= ok_s1;
			out_value_q <= rd_s1 ? rdata : '0;
			out_count_q <= cnt_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {7'd0, out_count_q, out_value_q};

	// Checks on the queue and stage logic.
	`RDEQ_ASSERT(a_occ_bound, occ_q <= CW'(rdeq_pkg::DEPTH), "occupancy beyond ring size")
	`RDEQ_ASSERT_IMPL(a_rd_nonempty, rd_en, !empty && !wr_en, "ring read on empty queue")
	`RDEQ_ASSERT_IMPL(a_wr_notfull, wr_en, !full && !rd_en, "ring write on full queue")
	`RDEQ_ASSERT_NEXT(a_rd_to_s1, rd_en, s1_valid_q && rd_s1, "read result lost from stage")
	`RDEQ_ASSERT_IMPL(a_stall_blocks, s1_valid_q && !s1_adv, !s_tready, "input taken over a full stage")
	`RDEQ_ASSERT_NEXT(a_ptr_span, acc && (nxt_occ == '0), front_q == back_q, "pointers differ on empty queue")

endmodule
